@@ hdl/sparse_gram_column_product_macros.svh @@
// assertion macros for the sparse gram column product
`ifndef SPARSE_GRAM_COLUMN_PRODUCT_MACROS_SVH
`define SPARSE_GRAM_COLUMN_PRODUCT_MACROS_SVH

`ifndef SYNTH
`define SGCP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sgcp check failed");
`define SGCP_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("sgcp forbidden condition");
`else
`define SGCP_ASSERT(lbl, prop)
`define SGCP_ASSERT_NEVER(lbl, expr)
`endif

`endif

@@ hdl/sgcp_pkg.sv @@
// types, sizes and codes shared by the sparse gram column product
`timescale 1ns / 1ps
`default_nettype none
package sgcp_pkg;

  localparam int MAX_ROWS     = 1024;
  localparam int MAX_COLUMNS  = 256;
  localparam int MAX_NONZEROS = 4096;

  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int COL_AW = $clog2(MAX_COLUMNS);
  localparam int NZ_AW  = $clog2(MAX_NONZEROS);
  localparam int NZ_CW  = NZ_AW + 1;

  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 48;
  localparam int CFG_DW = 11;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_DROP = 2'd2;

  localparam logic [1:0] CFG_SEL  = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_COLS = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [9:0]        row_index;
    logic [7:0]        column_index;
    logic signed [15:0] entry_value;
  } sgcp_in_t;

  typedef struct packed {
    logic [7:0]         result_column;
    logic signed [47:0] product;
    logic [1:0]         status;
  } sgcp_out_t;

  typedef struct packed {
    logic clr;
    logic add;
  } sgcp_mac_ctl_t;

endpackage
`default_nettype wire

@@ hdl/sparse_gram_column_product.sv @@
// top level: request sequencer, nonzero, column and dense stores
//
// Requests enter on in_data when start is high and busy is low. A clear
// (req 0) zeroes the column counts at once and then sweeps the dense column
// store, one row a cycle, with busy high until the sweep is done. The same
// sweep runs right after reset, so the block is busy until it is done
// before it takes its first request.
// A load (req 1) first reads the column record, then writes the nonzero
// and the column record, and the dense entry when the column is the one
// selected by CFG_SEL. Dropped loads stay idle and only set the drop flag.
// A query (req 2) walks the queried column's n nonzeros through a 4-stage
// read, read, multiply, accumulate path, one nonzero a cycle, and its result
// beat shows on out_data with out_valid high for one cycle once the path
// has drained; the next request may be accepted in the cycle that the beat
// shows.
// The result channel has no back pressure: every beat is taken as shown.
// Configuration writes on cfg_* are always taken (cfg_ready is high) and
// are expected only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_gram_column_product_macros.svh"
module sparse_gram_column_product (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire sgcp_pkg::sgcp_in_t             in_data,
  output logic                                out_valid,
  output sgcp_pkg::sgcp_out_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [sgcp_pkg::CFG_DW-1:0]    cfg_data
);
  import sgcp_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_HEAD  = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;

  localparam int ENT_W = ROW_AW + VAL_W;
  localparam int COLR_W = NZ_AW + NZ_CW;

  logic [2:0]             state_r, state_nxt;
  logic [ROW_AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  sgcp_in_t               req_r, req_nxt;
  logic [NZ_CW-1:0]       nz_cnt_r, nz_cnt_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [MAX_COLUMNS-1:0] col_vld_r, col_vld_nxt;
  logic [NZ_CW-1:0]       k_r, k_nxt;
  logic [NZ_CW-1:0]       end_r, end_nxt;
  logic                   s1_v_r, s2_v_r, p_v_r;
  logic signed [VAL_W-1:0]  val1_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                   out_valid_r, out_valid_nxt;
  sgcp_out_t              out_data_r, out_data_nxt;
  logic [7:0]             sel_r;
  logic [10:0]            rows_r;
  logic [8:0]             cols_r;

  logic                   accept, issue;
  logic [31:0]            in_row_ext, in_col_ext, req_row_ext, req_col_ext;
  logic                   in_row_ok, in_col_ok, req_col_ok, store_full;
  logic [COL_AW-1:0]      in_col_addr, req_col_addr;
  logic                   col_hit;

  logic                   ent_we;
  logic [ENT_W-1:0]       ent_wdata, ent_rdata;
  logic                   colr_we;
  logic [COLR_W-1:0]      colr_wdata, colr_rdata;
  logic                   den_we;
  logic [ROW_AW-1:0]      den_waddr;
  logic [VAL_W-1:0]       den_wdata, den_rdata;

  logic [NZ_AW-1:0]       col_first;
  logic [NZ_CW-1:0]       col_cnt;
  logic [NZ_CW:0]         col_end_raw;
  logic [NZ_CW-1:0]       col_end;

  sgcp_mac_ctl_t          mac_ctl;
  logic signed [ACC_W-1:0] mac_acc;
  logic                   mac_sat;

  assign accept      = start && !busy;
  assign in_row_ext  = 32'(in_data.row_index);
  assign in_col_ext  = 32'(in_data.column_index);
  assign req_row_ext = 32'(req_r.row_index);
  assign req_col_ext = 32'(req_r.column_index);
  assign in_col_addr = in_col_ext[COL_AW-1:0];
  assign req_col_addr = req_col_ext[COL_AW-1:0];

  assign in_row_ok  = (in_row_ext < 32'(rows_r)) && (in_row_ext < 32'(MAX_ROWS));
  assign in_col_ok  = (in_col_ext < 32'(cols_r)) && (in_col_ext < 32'(MAX_COLUMNS));
  assign req_col_ok = (req_col_ext < 32'(cols_r)) && (req_col_ext < 32'(MAX_COLUMNS));
  assign store_full = nz_cnt_r >= (NZ_CW)'(MAX_NONZEROS);
  assign col_hit    = col_vld_r[req_col_addr];

  assign col_first   = colr_rdata[NZ_CW +: NZ_AW];
  assign col_cnt     = colr_rdata[NZ_CW-1:0];
  assign col_end_raw = (NZ_CW+1)'(col_first) + (NZ_CW+1)'(col_cnt);
  assign col_end     = (col_end_raw > (NZ_CW+1)'(nz_cnt_r)) ? nz_cnt_r
                                                            : col_end_raw[NZ_CW-1:0];

  assign issue = (state_r == ST_WALK) && (k_r != end_r);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    req_nxt       = req_r;
    nz_cnt_nxt    = nz_cnt_r;
    ovf_nxt       = ovf_r;
    col_vld_nxt   = col_vld_r;
    k_nxt         = k_r;
    end_nxt       = end_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mac_ctl       = '0;
    ent_we        = 1'b0;
    ent_wdata     = {req_row_ext[ROW_AW-1:0], req_r.entry_value};
    colr_we       = 1'b0;
    colr_wdata    = '0;
    den_we        = 1'b0;
    den_waddr     = req_row_ext[ROW_AW-1:0];
    den_wdata     = req_r.entry_value;
    case (state_r)
      ST_CLEAR: begin
        den_we    = 1'b1;
        den_waddr = clr_cnt_r;
        den_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == (ROW_AW)'(MAX_ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          req_nxt = in_data;
          case (in_data.req_type)
            REQ_CLEAR: begin
              col_vld_nxt = '0;
              nz_cnt_nxt  = '0;
              ovf_nxt     = 1'b0;
              clr_cnt_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            REQ_LOAD: begin
              if (store_full || !in_row_ok || !in_col_ok) begin
                ovf_nxt = 1'b1;
              end else begin
                state_nxt = ST_LOAD;
              end
            end
            REQ_QUERY: begin
              state_nxt = ST_HEAD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD: begin
        ent_we  = 1'b1;
        colr_we = 1'b1;
        colr_wdata = col_hit ? {col_first, col_cnt + 1'b1}
                             : {nz_cnt_r[NZ_AW-1:0], (NZ_CW)'(1)};
        col_vld_nxt[req_col_addr] = 1'b1;
        nz_cnt_nxt = nz_cnt_r + 1'b1;
        den_we = (req_r.column_index == sel_r);
        state_nxt = ST_IDLE;
      end
      ST_HEAD: begin
        mac_ctl.clr = 1'b1;
        if (req_col_ok && col_hit) begin
          k_nxt   = (NZ_CW)'(col_first);
          end_nxt = col_end;
        end else begin
          k_nxt   = '0;
          end_nxt = '0;
        end
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (issue) begin
          k_nxt = k_r + 1'b1;
        end else if (!s1_v_r && !s2_v_r && !p_v_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.result_column = req_r.column_index;
          out_data_nxt.product = mac_acc;
          out_data_nxt.status  = mac_sat ? STAT_SAT : (ovf_r ? STAT_DROP : STAT_OK);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    mac_ctl.add = p_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      nz_cnt_r    <= '0;
      ovf_r       <= 1'b0;
      col_vld_r   <= '0;
      k_r         <= '0;
      end_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      p_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
      sel_r       <= '0;
      rows_r      <= 11'd1024;
      cols_r      <= 9'd256;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      nz_cnt_r    <= nz_cnt_nxt;
      ovf_r       <= ovf_nxt;
      col_vld_r   <= col_vld_nxt;
      k_r         <= k_nxt;
      end_r       <= end_nxt;
      s1_v_r      <= issue;
      s2_v_r      <= s1_v_r;
      p_v_r       <= s2_v_r;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SEL:  sel_r  <= cfg_data[7:0];
          CFG_ROWS: rows_r <= cfg_data[10:0];
          CFG_COLS: cols_r <= cfg_data[8:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
    val1_r     <= $signed(ent_rdata[VAL_W-1:0]);
    prod_r     <= (PROD_W)'(val1_r * $signed(den_rdata));
  end

  sgcp_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NONZEROS)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (nz_cnt_r[NZ_AW-1:0]),
    .wdata (ent_wdata),
    .raddr (k_r[NZ_AW-1:0]),
    .rdata (ent_rdata)
  );

  sgcp_ram #(.WIDTH(COLR_W), .DEPTH(MAX_COLUMNS)) u_col_ram (
    .clk   (clk),
    .we    (colr_we),
    .waddr (req_col_addr),
    .wdata (colr_wdata),
    .raddr (in_col_addr),
    .rdata (colr_rdata)
  );

  sgcp_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS)) u_den_ram (
    .clk   (clk),
    .we    (den_we),
    .waddr (den_waddr),
    .wdata (den_wdata),
    .raddr (ent_rdata[VAL_W +: ROW_AW]),
    .rdata (den_rdata)
  );

  sgcp_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .prod  (prod_r),
    .acc   (mac_acc),
    .sat   (mac_sat)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  `SGCP_ASSERT(a_out_after_walk, out_valid |-> $past(state_r == ST_WALK))
  `SGCP_ASSERT(a_walk_bound, (state_r == ST_WALK) |-> (k_r <= end_r))
  `SGCP_ASSERT(a_load_from_idle, (state_r == ST_LOAD) |-> $past(state_r == ST_IDLE))
  `SGCP_ASSERT(a_nz_bound, nz_cnt_r <= (NZ_CW)'(MAX_NONZEROS))
  `SGCP_ASSERT_NEVER(a_idle_drained, (state_r == ST_IDLE) && (s1_v_r || s2_v_r || p_v_r))

endmodule
`default_nettype wire

@@ hdl/sgcp_ram.sv @@
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module sgcp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hdl/sgcp_mac.sv @@
// saturating 48-bit accumulator for the column walk
`timescale 1ns / 1ps
`default_nettype none
module sgcp_mac (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sgcp_pkg::sgcp_mac_ctl_t     ctl,
  input  wire logic signed [sgcp_pkg::PROD_W-1:0] prod,
  output logic signed      [sgcp_pkg::ACC_W-1:0]  acc,
  output logic                             sat
);
  import sgcp_pkg::*;

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    sat_r, sat_nxt;
  logic signed [ACC_W:0]   sum;

  always_comb begin
    sum     = (ACC_W+1)'(acc_r) + (ACC_W+1)'(prod);
    acc_nxt = acc_r;
    sat_nxt = sat_r;
    if (ctl.clr) begin
      acc_nxt = '0;
      sat_nxt = 1'b0;
    end else if (ctl.add) begin
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        sat_nxt = 1'b1;
        acc_nxt = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_nxt = sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      sat_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign acc = acc_r;
  assign sat = sat_r;

endmodule
`default_nettype wire

@@ bench/sparse_gram_column_product_test.sv @@
// testbench for the sparse gram column product: directed table, then random episodes vs a model
`timescale 1ns / 1ps
module sparse_gram_column_product_test;
  import sgcp_pkg::*;

  localparam logic [1:0] REQ_IGNORED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int REPORT_LINES = 100;
  localparam longint ACC_TOP = 64'sd140737488355327;
  localparam longint ACC_BOTTOM = -ACC_TOP - 1;

  typedef struct {
    bit               is_cfg;
    logic [1:0]       reg_idx;
    int unsigned      reg_val;
    sgcp_in_t         item;
    bit               typed;
    sgcp_out_t        want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  sgcp_in_t            in_data;
  logic                out_valid;
  sgcp_out_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [CFG_DW-1:0]   cfg_data;

  // model of the matrix stores and registers
  logic [9:0]          nz_row [MAX_NONZEROS];
  logic signed [15:0]  nz_val [MAX_NONZEROS];
  int unsigned         col_first [MAX_COLUMNS];
  int unsigned         col_len [MAX_COLUMNS];
  logic signed [15:0]  dense_sel [MAX_ROWS];
  int unsigned         nz_count;
  bit                  load_dropped;
  logic [7:0]          sel_col;
  int unsigned         row_lim;
  int unsigned         col_lim;

  sgcp_out_t           pending_products[$];
  plan_row_t           directed[$];
  int unsigned         sender_idle_pct;
  int unsigned         requests_sent;
  int unsigned         drops_modeled;
  int unsigned         reg_writes;
  int unsigned         results_checked;
  int unsigned         mismatches;
  int unsigned         quiet_cycles;

  sparse_gram_column_product DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report(input string msg);
    if (mismatches < REPORT_LINES) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  function automatic void matrix_clear();
    foreach (col_len[c]) col_len[c] = 0;
    foreach (dense_sel[r]) dense_sel[r] = '0;
    nz_count = 0;
    load_dropped = 0;
  endfunction

  function automatic void set_register(input logic [1:0] idx, input int unsigned val);
    int unsigned v;
    case (idx)
      CFG_SEL: sel_col = val[7:0];
      CFG_ROWS: begin
        v = val & 'h7FF;
        row_lim = (v < MAX_ROWS) ? v : MAX_ROWS;
      end
      CFG_COLS: begin
        v = val & 'h1FF;
        col_lim = (v < MAX_COLUMNS) ? v : MAX_COLUMNS;
      end
      default: ;
    endcase
  endfunction

  // applies one request to the model, returns 1 with the column product for a query
  function automatic bit gram_step(input sgcp_in_t it, output sgcp_out_t res);
    longint      acc;
    bit          sat;
    int unsigned k, first, last;
    logic [7:0]  c;
    c = it.column_index;
    res = '0;
    case (it.req_type)
      REQ_CLEAR: begin
        matrix_clear();
        return 0;
      end
      REQ_LOAD: begin
        if (nz_count >= MAX_NONZEROS || it.row_index >= row_lim || c >= col_lim) begin
          load_dropped = 1;
          drops_modeled++;
        end else begin
          nz_row[nz_count] = it.row_index;
          nz_val[nz_count] = it.entry_value;
          if (col_len[c] == 0) col_first[c] = nz_count;
          col_len[c]++;
          nz_count++;
          if (c == sel_col) dense_sel[it.row_index] = it.entry_value;
        end
        return 0;
      end
      REQ_QUERY: begin
        acc = 0;
        sat = 0;
        if (c < col_lim && col_len[c] > 0) begin
          first = col_first[c];
          last = first + col_len[c];
          if (last > nz_count) last = nz_count;
          for (k = first; k < last; k++) begin
            acc += longint'(nz_val[k]) * longint'(dense_sel[nz_row[k]]);
            if (acc > ACC_TOP) begin
              acc = ACC_TOP;
              sat = 1;
            end
            if (acc < ACC_BOTTOM) begin
              acc = ACC_BOTTOM;
              sat = 1;
            end
          end
        end
        res.result_column = c;
        res.product = acc[47:0];
        res.status = sat ? STAT_SAT : (load_dropped ? STAT_DROP : STAT_OK);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic logic signed [15:0] entry_sample();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return -16'sd1;
      3: return 16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void plan_item(input logic [1:0] req, input int unsigned row,
                                    input int unsigned col, input int val);
    plan_row_t p;
    p.is_cfg = 0;
    p.reg_idx = CFG_SEL;
    p.reg_val = 0;
    p.item.req_type = req;
    p.item.row_index = row[9:0];
    p.item.column_index = col[7:0];
    p.item.entry_value = val[15:0];
    p.typed = 0;
    p.want = '0;
    directed.push_back(p);
  endfunction

  // query whose product is zero by construction
  function automatic void plan_fixed(input int unsigned col, input logic [1:0] status);
    plan_item(REQ_QUERY, 0, col, 0);
    directed[directed.size()-1].typed = 1;
    directed[directed.size()-1].want.result_column = col[7:0];
    directed[directed.size()-1].want.product = '0;
    directed[directed.size()-1].want.status = status;
  endfunction

  function automatic void plan_cfg(input logic [1:0] idx, input int unsigned val);
    plan_row_t p;
    p.is_cfg = 1;
    p.reg_idx = idx;
    p.reg_val = val;
    p.item = '0;
    p.typed = 0;
    p.want = '0;
    directed.push_back(p);
  endfunction

  // stop sending and wait until the block has nothing left to do
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (busy == 1'b1 || pending_products.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DW-1:0];
    do @(posedge clk); while (cfg_ready != 1'b1);
    cfg_valid <= 1'b0;
    set_register(idx, val);
    reg_writes++;
  endtask

  task automatic send_item(input sgcp_in_t it, input bit typed, input sgcp_out_t want);
    sgcp_out_t res;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy == 1'b1);
    requests_sent++;
    if (gram_step(it, res)) pending_products.push_back(typed ? want : res);
  endtask

  // set the registers, clear, then column-ordered loads mixed with queries and some noise
  task automatic run_episode(input int unsigned sel, input int unsigned rows,
                             input int unsigned cols, input int unsigned n_items,
                             input int unsigned idle_pct, input int unsigned noise_pct,
                             input int unsigned query_pct, input int unsigned step_pct);
    sgcp_in_t    it;
    int unsigned col, first_col, rspan, roll, q, i;
    write_reg(CFG_SEL, sel);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
    sender_idle_pct = idle_pct;
    it = '0;
    it.req_type = REQ_CLEAR;
    send_item(it, 0, '0);
    first_col = (sel > 4) ? sel - $urandom_range(0, 4) : 0;
    if (first_col >= col_lim) first_col = 0;
    col = first_col;
    rspan = (row_lim < 48) ? row_lim : 48;
    for (i = 0; i < n_items; i++) begin
      roll = $urandom_range(99);
      it.row_index = 10'($urandom_range(0, 1023));
      it.column_index = 8'($urandom_range(0, 255));
      it.entry_value = entry_sample();
      if (roll < noise_pct) begin
        q = $urandom_range(19);
        it.req_type = (q == 0) ? REQ_CLEAR : (q < 8) ? REQ_IGNORED :
                      (q < 14) ? REQ_LOAD : REQ_QUERY;
      end else if (roll < noise_pct + query_pct) begin
        it.req_type = REQ_QUERY;
        if ($urandom_range(9) != 0) begin
          q = first_col + $urandom_range(0, 15);
          it.column_index = (q > 255) ? 8'd255 : q[7:0];
        end
      end else begin
        it.req_type = REQ_LOAD;
        if ($urandom_range(99) < step_pct && col + 1 < col_lim) col++;
        it.column_index = col[7:0];
        if ($urandom_range(7) != 0) it.row_index = 10'($urandom_range(0, rspan - 1));
        else it.row_index = 10'($urandom_range(0, row_lim - 1));
      end
      send_item(it, 0, '0);
    end
  endtask

  always @(posedge clk) begin : check_results
    sgcp_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_products.size() == 0) begin
        report($sformatf("result beat for column %0d with none expected",
                         out_data.result_column));
      end else begin
        want = pending_products.pop_front();
        results_checked++;
        if (out_data.result_column !== want.result_column)
          report($sformatf("column: got %0d, want %0d", out_data.result_column,
                           want.result_column));
        if (out_data.product !== want.product)
          report($sformatf("product of column %0d: got %0d, want %0d",
                           want.result_column, out_data.product, want.product));
        if (out_data.status !== want.status)
          report($sformatf("status of column %0d: got %0d, want %0d",
                           want.result_column, out_data.status, want.status));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned ep, sel, rows, cols, idle;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SEL;
    cfg_data = '0;
    quiet_cycles = 0;
    sender_idle_pct = 0;
    requests_sent = 0;
    drops_modeled = 0;
    reg_writes = 0;
    results_checked = 0;
    mismatches = 0;
    sel_col = '0;
    row_lim = MAX_ROWS;
    col_lim = MAX_COLUMNS;
    foreach (col_first[c]) col_first[c] = 0;
    matrix_clear();

    plan_fixed(0, STAT_OK);
    plan_fixed(255, STAT_OK);
    plan_item(REQ_LOAD, 0, 0, 32767);
    plan_item(REQ_LOAD, 1023, 0, -32768);
    plan_item(REQ_LOAD, 5, 0, 1);
    plan_item(REQ_QUERY, 0, 0, 0);
    plan_item(REQ_LOAD, 0, 255, -32768);
    plan_item(REQ_LOAD, 1023, 255, -32768);
    plan_item(REQ_QUERY, 0, 255, 0);
    // out of column order: the walk of column 0 runs into column 255
    plan_item(REQ_LOAD, 5, 0, -1);
    plan_item(REQ_QUERY, 0, 0, 0);
    plan_item(REQ_IGNORED, 1023, 255, -1);
    plan_fixed(128, STAT_OK);
    // dense copy keeps the old selection
    plan_cfg(CFG_SEL, 255);
    plan_item(REQ_QUERY, 0, 255, 0);
    plan_cfg(CFG_ROWS, 1);
    plan_cfg(CFG_COLS, 1);
    plan_item(REQ_LOAD, 1, 0, 5);
    plan_item(REQ_LOAD, 0, 1, 5);
    plan_fixed(200, STAT_DROP);
    plan_item(REQ_QUERY, 0, 0, 0);
    plan_item(REQ_CLEAR, 0, 0, 0);
    plan_fixed(0, STAT_OK);
    plan_item(REQ_LOAD, 0, 0, -32768);
    plan_fixed(0, STAT_OK);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_reg(directed[i].reg_idx, directed[i].reg_val);
      else send_item(directed[i].item, directed[i].typed, directed[i].want);
    end

    for (ep = 0; ep < 10; ep++) begin
      case (ep)
        0: begin sel = 255; rows = 1024; cols = 256; end
        1: begin sel = 0; rows = 1; cols = 1; end
        2: begin sel = 0; rows = 1024; cols = 256; end
        default: begin
          case ($urandom_range(2))
            0: rows = 1;
            1: rows = 1024;
            default: rows = $urandom_range(2, 1024);
          endcase
          case ($urandom_range(2))
            0: cols = 1;
            1: cols = 256;
            default: cols = $urandom_range(2, 256);
          endcase
          sel = ($urandom_range(4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, cols - 1);
        end
      endcase
      case (ep % 3)
        0: idle = 0;
        1: idle = 69;
        default: idle = 13;
      endcase
      run_episode(sel, rows, cols, 60, idle, 15, 30, 20);
    end
    // longer run of loads with sparse queries
    run_episode($urandom_range(0, 15), 1024, 256, 368, 0, 0, 4, 5);

    settle();
    $display("sent %0d requests over 11 episodes and a directed table, %0d loads dropped",
             requests_sent, drops_modeled);
    $display("checked %0d column products after %0d register writes, %0d mismatches",
             results_checked, reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
